/* design/htlp_pkg.sv */
// ----------------------------------------------------------------------------
// htlp_pkg: shared types and constants of the hash table lookup
// Sizes of the bucket and key stores, field widths and request codes.
// ----------------------------------------------------------------------------
package htlp_pkg;

  localparam int BUCKET_SLOTS = 8192;
  localparam int ENTRY_DEPTH  = 4096;

  localparam int BUCKET_AW = $clog2(BUCKET_SLOTS);
  localparam int ENTRY_AW  = $clog2(ENTRY_DEPTH);

  localparam int OP_W      = 2;
  localparam int ADDR_W    = 13;
  localparam int VALUE_W   = 16;
  localparam int KEY_W     = 64;
  localparam int REG_W     = 13;
  localparam int INDEX_W   = 12;
  localparam int CFG_IDX_W = 1;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [REG_W-1:0]   reg_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Bucket word: empty mark above the entry index.
  typedef struct packed {
    logic   empty;
    value_t entry;
  } bucket_word_t;

  localparam op_t OP_WR_BUCKET = 2'd0;
  localparam op_t OP_WR_KEY    = 2'd1;
  localparam op_t OP_LOOKUP    = 2'd2;

  localparam cfg_idx_t CFG_BUCKET_MASK = 1'd0;
  localparam cfg_idx_t CFG_ASSET_COUNT = 1'd1;

endpackage

/* design/hash_table_linear_probe_lookup_top.sv */
// ----------------------------------------------------------------------------
// hash_table_linear_probe_lookup_top: open-addressing table lookup
// Bucket store and key store in synchronous RAMs, linear probing sequencer.
// ----------------------------------------------------------------------------
// Operation: a write is done at the edge that accepts it. An empty-table lookup finishes
//   at that edge; any other reads the bucket word into a register, inspects it in
//   S_CHECK, reads and compares a live entry's key in S_KEY, slot by slot, until a hit,
//   an empty slot or the last probe; a result meeting a busy output waits in S_DONE.
// Throughput: one request in flight; the next is taken once back in S_IDLE.
// Reset: rst clears the sequencer, result valid and both registers only.
module hash_table_linear_probe_lookup_top (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  htlp_pkg::op_t       op,
  input  htlp_pkg::addr_t     address,
  input  logic                slot_empty,
  input  htlp_pkg::value_t    entry_value,
  input  htlp_pkg::key_t      key,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                found,
  output htlp_pkg::index_t    entry_index,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  htlp_pkg::cfg_idx_t  cfg_index,
  input  htlp_pkg::reg_t      cfg_data
);
  import htlp_pkg::*;

  // Sequencer codes
  localparam logic [1:0] S_IDLE  = 2'd0;  // take requests
  localparam logic [1:0] S_CHECK = 2'd1;  // bucket word ready to inspect
  localparam logic [1:0] S_KEY   = 2'd2;  // stored key ready to compare
  localparam logic [1:0] S_DONE  = 2'd3;  // result waits for a free output

  logic [1:0] state, state_next;

  // Configuration registers
  reg_t bucket_mask;
  reg_t asset_count;

  // Lookup context
  key_t                  lkey;
  logic [BUCKET_AW-1:0]  slot, slot_next;
  reg_t                  probes_left, probes_left_next;
  index_t                entry_q;

  // Pending result when the output register is still occupied
  logic   pend_found;
  index_t pend_index;

  // RAMs
  bucket_word_t          bucket_mem [BUCKET_SLOTS];
  key_t                  key_mem    [ENTRY_DEPTH];
  bucket_word_t          bucket_q;
  key_t                  key_q;

  logic                  bkt_we, bkt_re;
  logic [BUCKET_AW-1:0]  bkt_wa, bkt_ra;
  bucket_word_t          bkt_wd;
  logic                  key_we, key_re;
  logic [ENTRY_AW-1:0]   key_wa, key_ra;

  // Lookup finish
  logic   fin, fin_found;
  index_t fin_index;

  logic in_fire, res_free, entry_ok, last_probe;
  logic [BUCKET_AW-1:0] next_slot, start_slot;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign res_free  = !out_valid || out_ready;

  // Slot arithmetic: wrap under the mask
  assign start_slot = BUCKET_AW'(key[ADDR_W-1:0] & bucket_mask);
  assign next_slot  = BUCKET_AW'((REG_W'(slot) + REG_W'(1)) & bucket_mask);
  assign last_probe = (probes_left == '0);

  // Entry index must be a live entry and lie inside the key store
  assign entry_ok = (bucket_q.entry < VALUE_W'(asset_count)) &&
                    (32'(bucket_q.entry) < ENTRY_DEPTH);

  assign bkt_wa = BUCKET_AW'(address);
  assign bkt_wd = '{empty: slot_empty, entry: entry_value};
  assign key_wa = ENTRY_AW'(address);

  always_comb begin
    state_next       = state;
    slot_next        = slot;
    probes_left_next = probes_left;
    bkt_we           = 1'b0;
    bkt_re           = 1'b0;
    bkt_ra           = slot;
    key_we           = 1'b0;
    key_re           = 1'b0;
    key_ra           = ENTRY_AW'(bucket_q.entry);
    fin              = 1'b0;
    fin_found        = 1'b0;
    fin_index        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (op)
            OP_WR_BUCKET: bkt_we = (32'(address) < BUCKET_SLOTS);
            OP_WR_KEY:    key_we = (32'(address) < ENTRY_DEPTH);
            OP_LOOKUP: begin
              if (asset_count == '0) begin
                // empty table: answer a miss at once
                fin = 1'b1;
              end else begin
                bkt_re           = 1'b1;
                bkt_ra           = start_slot;
                slot_next        = start_slot;
                probes_left_next = bucket_mask;
                state_next       = S_CHECK;
              end
            end
            default: ;  // unused code: drop
          endcase
        end
      end
      S_CHECK: begin
        if (bucket_q.empty) begin
          fin = 1'b1;
        end else if (entry_ok) begin
          key_re     = 1'b1;
          state_next = S_KEY;
        end else if (last_probe) begin
          fin = 1'b1;
        end else begin
          bkt_re           = 1'b1;
          bkt_ra           = next_slot;
          slot_next        = next_slot;
          probes_left_next = probes_left - REG_W'(1);
        end
      end
      S_KEY: begin
        if (key_q == lkey) begin
          fin       = 1'b1;
          fin_found = 1'b1;
          fin_index = entry_q;
        end else if (last_probe) begin
          fin = 1'b1;
        end else begin
          bkt_re           = 1'b1;
          bkt_ra           = next_slot;
          slot_next        = next_slot;
          probes_left_next = probes_left - REG_W'(1);
          state_next       = S_CHECK;
        end
      end
      S_DONE: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // Finished lookup: straight to the output if free, else park it
    if (fin) begin
      state_next = res_free ? S_IDLE : S_DONE;
    end
  end

  // Bucket store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bucket_mem[bkt_wa] <= bkt_wd;
    end
    if (bkt_re) begin
      bucket_q <= bucket_mem[bkt_ra];
    end
  end

  // Key store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key;
    end
    if (key_re) begin
      key_q <= key_mem[key_ra];
    end
  end

  // Lookup context and pending result
  always_ff @(posedge clk) begin
    slot        <= slot_next;
    probes_left <= probes_left_next;
    if (in_fire) begin
      lkey <= key;
    end
    if (key_re) begin
      entry_q <= INDEX_W'(bucket_q.entry);
    end
    if (fin && !res_free) begin
      pend_found <= fin_found;
      pend_index <= fin_index;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin && res_free) begin
      out_valid <= 1'b1;
    end else if (state == S_DONE && res_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin && res_free) begin
      found       <= fin_found;
      entry_index <= fin_index;
    end else if (state == S_DONE && res_free) begin
      found       <= pend_found;
      entry_index <= pend_index;
    end
  end

  // Sequencer and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      bucket_mask <= '0;
      asset_count <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_BUCKET_MASK: bucket_mask <= cfg_data;
          CFG_ASSET_COUNT: asset_count <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the linear-probing hash table lookup
// Loads bucket and key stores through the request channel, sends lookups and
// checks every result against a software probe of mirrored stores, under
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
  import htlp_pkg::*;

  // Code 3 is not named in the package; the block must drop it silently.
  localparam op_t OP_UNUSED    = 2'd3;
  // Leave a margin after writes before touching registers.
  localparam int  SETTLE_CYCLES = 20;

  typedef struct packed {
    logic   found;
    index_t entry_index;
  } answer_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  op_t      op = OP_WR_BUCKET;
  addr_t    address = '0;
  logic     slot_empty = 1'b0;
  value_t   entry_value = '0;
  key_t     key = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  logic     found;
  index_t   entry_index;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = CFG_BUCKET_MASK;
  reg_t     cfg_data = '0;

  hash_table_linear_probe_lookup_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .address     (address),
    .slot_empty  (slot_empty),
    .entry_value (entry_value),
    .key         (key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .entry_index (entry_index),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Mirror of the block: both stores, a written flag per word, both registers
  // --------------------------------------------------------------------------
  bucket_word_t bucket_mirror [BUCKET_SLOTS];
  bit           slot_known    [BUCKET_SLOTS];
  key_t         key_mirror    [ENTRY_DEPTH];
  bit           key_known     [ENTRY_DEPTH];
  reg_t         mask_q  = '0;
  reg_t         count_q = '0;

  // Answers still owed by the block, oldest first.
  answer_t      lookup_answers [$];
  // Entries placed in the current table, used to aim lookups at real keys.
  int           placed [$];

  bit steady_flow = 1'b0;
  int faults      = 0;
  int n_lookups   = 0;
  int n_hits      = 0;
  int n_writes    = 0;
  int n_ignored   = 0;
  int n_results   = 0;

  // Walk the mirrored table exactly as the block must. The return value says
  // whether every word touched on the way has been written, so that no lookup
  // is ever sent that would read an undefined store word.
  function automatic bit predict_lookup(input key_t k, output answer_t ans);
    int           slot;
    bucket_word_t w;
    ans = '0;
    if (count_q == 0) return 1'b1;
    slot = int'(k[ADDR_W-1:0] & mask_q);
    repeat (int'(mask_q) + 1) begin
      if (!slot_known[slot]) return 1'b0;
      w = bucket_mirror[slot];
      if (w.empty) return 1'b1;
      // Entries at or past the asset count, or past the key store, are skipped.
      if (w.entry < count_q && w.entry < ENTRY_DEPTH) begin
        if (!key_known[w.entry]) return 1'b0;
        if (key_mirror[w.entry] == k) begin
          ans.found       = 1'b1;
          ans.entry_index = w.entry[INDEX_W-1:0];
          return 1'b1;
        end
      end
      slot = (slot + 1) & int'(mask_q);
    end
    // Every slot probed without a stop: a miss.
    return 1'b1;
  endfunction

  function automatic key_t any_key();
    return {$urandom, $urandom};
  endfunction

  // Mostly back-to-back, some short pauses, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Update the mirror for one accepted request, queue the answer of a lookup.
  function automatic void apply_request(op_t o, addr_t a, logic e, value_t v, key_t k);
    answer_t ans;
    case (o)
      OP_WR_BUCKET: begin
        bucket_mirror[a] = '{empty: e, entry: v};
        slot_known[a]    = 1'b1;
        n_writes++;
      end
      OP_WR_KEY: begin
        if (a < ENTRY_DEPTH) begin
          key_mirror[a] = k;
          key_known[a]  = 1'b1;
          n_writes++;
        end else begin
          n_ignored++;
        end
      end
      OP_LOOKUP: begin
        void'(predict_lookup(k, ans));
        lookup_answers.push_back(ans);
        n_lookups++;
        if (ans.found) n_hits++;
      end
      default: n_ignored++;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Every task here is entered and left on a rising edge.
  // --------------------------------------------------------------------------
  task automatic send_request(op_t o, addr_t a, logic e, value_t v, key_t k);
    int gap;
    gap = pick_gap();
    // Drop valid only when a pause is wanted; otherwise keep it high and
    // present the next request straight away.
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    address     <= a;
    slot_empty  <= e;
    entry_value <= v;
    key         <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_request(o, a, e, v, k);
  endtask

  task automatic write_bucket(int slot, logic e, value_t v);
    send_request(OP_WR_BUCKET, addr_t'(slot), e, v, any_key());
  endtask

  task automatic write_key(int entry, key_t k);
    send_request(OP_WR_KEY, addr_t'(entry), 1'($urandom), value_t'($urandom), k);
  endtask

  task automatic lookup(key_t k);
    send_request(OP_LOOKUP, addr_t'($urandom), 1'($urandom), value_t'($urandom), k);
  endtask

  // Hold requests until every answer is in, then let in-flight writes settle.
  task automatic wait_until_quiet();
    in_valid <= 1'b0;
    while (lookup_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only ever called while the block is idle.
  task automatic write_register(cfg_idx_t idx, reg_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_BUCKET_MASK) mask_q = data;
    else count_q = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Insert an entry whose key is already stored: take the first free slot
  // from its home slot onwards and close the run with an empty mark if the
  // following slot has never been written.
  task automatic place_entry(int entry);
    int slot;
    int nxt;
    slot = int'(key_mirror[entry][ADDR_W-1:0] & mask_q);
    repeat (int'(mask_q) + 1) begin
      if (!slot_known[slot] || bucket_mirror[slot].empty) begin
        write_bucket(slot, 1'b0, value_t'(entry));
        nxt = (slot + 1) & int'(mask_q);
        if (!slot_known[nxt]) write_bucket(nxt, 1'b1, value_t'($urandom));
        placed.push_back(entry);
        return;
      end
      slot = (slot + 1) & int'(mask_q);
    end
  endtask

  // Aim at a stored key, at a key sharing its home slot, or anywhere at all.
  // Retry a choice meeting an unwritten word at a stored home slot, else drop.
  task automatic random_lookup();
    key_t    k;
    key_t    hi;
    answer_t ans;
    int      pick;
    hi   = any_key() & ~key_t'(mask_q);
    pick = $urandom_range(0, 99);
    if (placed.size() != 0 && pick < 70) begin
      k = key_mirror[placed[$urandom_range(0, placed.size() - 1)]];
      // Same home slot, different key: walks the run and misses.
      if (pick >= 45) k = k ^ (hi | (key_t'(mask_q) + 1));
    end else begin
      k = any_key();
    end
    if (!predict_lookup(k, ans) && placed.size() != 0)
      k = hi | (key_mirror[placed[$urandom_range(0, placed.size() - 1)]] & key_t'(mask_q));
    if (predict_lookup(k, ans)) lookup(k);
  endtask

  // Requests that do not lead to a lookup result: dropped codes, key writes
  // beyond the key store, rewritten keys, stray bucket words.
  task automatic send_noise();
    int slot;
    int nxt;
    slot = int'($urandom) & int'(mask_q);
    nxt  = (slot + 1) & int'(mask_q);
    case ($urandom_range(0, 4))
      0: send_request(OP_UNUSED, addr_t'($urandom), 1'($urandom), value_t'($urandom),
                      any_key());
      1: write_key(ENTRY_DEPTH + $urandom_range(0, ENTRY_DEPTH - 1), any_key());
      2: begin
        if (placed.size() != 0)
          write_key(placed[$urandom_range(0, placed.size() - 1)], any_key());
        else
          send_request(OP_UNUSED, '0, 1'b0, '0, any_key());
      end
      3: begin
        // Entry index past the key store: never compared, probing goes on.
        write_bucket(slot, 1'b0, value_t'($urandom_range(ENTRY_DEPTH, 65535)));
        if (!slot_known[nxt]) write_bucket(nxt, 1'b1, value_t'($urandom));
      end
      default: write_bucket(slot, 1'b1, value_t'($urandom));
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the scoreboard
  // --------------------------------------------------------------------------
  int ready_hold = 0;

  always @(posedge clk) begin : stall_gen
    int pick;
    pick = $urandom_range(0, 99);
    if (rst) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (steady_flow) begin
      out_ready <= 1'b1;
    end else if (pick < 60) begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 7);
    end else if (pick < 90) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 2);
    end else begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(9, 39);
    end
  end

  task automatic flag_fault(string what);
    faults++;
    if (faults <= 10) $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : result_check
    answer_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (lookup_answers.size() == 0) begin
        flag_fault($sformatf("unexpected result found=%b entry_index=%0d",
                             found, entry_index));
      end else begin
        want = lookup_answers.pop_front();
        if (found !== want.found || entry_index !== want.entry_index)
          flag_fault($sformatf("result %0d: expected found=%b entry_index=%0d, got found=%b entry_index=%0d",
                               n_results, want.found, want.entry_index, found, entry_index));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Asset count is zero after reset: a miss without touching either store.
  task automatic test_empty_table();
    lookup('1);
    lookup('0);
  endtask

  // Four-slot table built by hand:
  //   slot 0: entry 0 (key 0)        slot 1: entry 0xffff, past the count
  //   slot 2: empty                  slot 3: entry 1 (key all ones)
  task automatic test_small_table();
    wait_until_quiet();
    write_register(CFG_BUCKET_MASK, reg_t'(3));
    write_register(CFG_ASSET_COUNT, reg_t'(4));
    write_key(0, '0);
    write_key(1, '1);
    write_key(2, 64'h8000_0000_0000_0002);
    write_key(3, 64'h7);
    write_key(8191, '1);                   // past the key store: dropped
    write_bucket(0, 1'b0, value_t'(0));
    write_bucket(1, 1'b0, '1);
    write_bucket(2, 1'b1, '1);
    write_bucket(3, 1'b0, value_t'(1));
    send_request(OP_UNUSED, '1, 1'b1, '1, '1);
    lookup('0);                            // hit in the home slot
    lookup('1);                            // hit in the last slot
    lookup(64'h5);                         // skip the stray entry, stop at empty
    lookup(64'h4);                         // key mismatch, then empty
    lookup(64'h8000_0000_0000_0002);       // home slot empty
    write_bucket(2, 1'b0, value_t'(2));
    lookup(64'h8000_0000_0000_0002);
    lookup(64'h6);                         // all four slots probed: miss
    write_bucket(1, 1'b0, value_t'(3));
    lookup(64'h7);                         // hit after wrapping round
  endtask

  // Asset count above the key store depth: an entry index that passes the
  // count check but lies beyond the key store must be skipped.
  task automatic test_entry_beyond_store();
    wait_until_quiet();
    write_register(CFG_ASSET_COUNT, reg_t'(8191));
    write_bucket(1, 1'b0, value_t'(5000));
    lookup(64'h5);
    lookup(64'h7);
  endtask

  // One table per call: set the registers, optionally mark the whole table
  // empty, fill it with n_entries random keys, then probe at random.
  task automatic run_table_phase(reg_t mask, reg_t count, int n_entries, int n_probes,
                                 bit clear_all);
    int   limit;
    int   entry;
    key_t k;
    wait_until_quiet();
    write_register(CFG_BUCKET_MASK, mask);
    write_register(CFG_ASSET_COUNT, count);
    placed.delete();
    limit = (count == 0 || count > ENTRY_DEPTH) ? ENTRY_DEPTH : int'(count);
    if (clear_all)
      for (int s = 0; s <= int'(mask); s++) write_bucket(s, 1'b1, value_t'($urandom));
    for (int i = 0; i < n_entries; i++) begin
      entry = $urandom_range(0, limit - 1);
      k     = any_key();
      // Share a home slot with the previous key now and then to grow runs.
      if (placed.size() != 0 && $urandom_range(0, 3) == 0)
        k = (k & ~key_t'(mask)) | (key_mirror[placed[$]] & key_t'(mask));
      write_key(entry, k);
      place_entry(entry);
      if ($urandom_range(0, 1) == 0) random_lookup();
    end
    for (int i = 0; i < n_probes; i++) begin
      if (i % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      // Halfway through, hold the requests until every answer is back.
      if (i == n_probes / 2) wait_until_quiet();
      if ($urandom_range(0, 9) == 0) send_noise();
      else random_lookup();
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_random_tables();
    run_table_phase(reg_t'(15),   reg_t'(16),   8,   40,  1'b1);
    run_table_phase(reg_t'(127),  reg_t'(200),  60,  150, 1'b1);
    // Single-slot table: every miss probes the whole table.
    run_table_phase(reg_t'(0),    reg_t'(4096), 1,   30,  1'b1);
    // Largest table, built sparsely so that only touched slots are written.
    run_table_phase(reg_t'(8191), reg_t'(4096), 150, 250, 1'b0);
    // Count of zero: all misses whatever the table holds.
    run_table_phase(reg_t'(1023), reg_t'(0),    40,  60,  1'b0);
    run_table_phase(reg_t'(31),   reg_t'(4096), 16,  120, 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_small_table();
    test_entry_beyond_store();
    test_random_tables();
    wait_until_quiet();
    $display("Ran %0d lookups (%0d hits, %0d misses), %0d store writes, %0d dropped requests,",
             n_lookups, n_hits, n_lookups - n_hits, n_writes, n_ignored);
    $display("over tables of 1 to 8192 slots with asset counts from 0 to 8191; %0d faults.",
             faults);
    if (faults == 0) begin
      $display("[hash_table_linear_probe_lookup_top] OK");
    end else begin
      $display("[hash_table_linear_probe_lookup_top] ERROR");
    end
    $finish;
  end

  // Far beyond the slowest legal run of this stimulus.
  initial begin
    #20_000_000;
    $display("[hash_table_linear_probe_lookup_top] ERROR");
    $finish;
  end

endmodule
